>>> sv/sfgr_pkg.sv
//------------------------------------------------------------------------------
// sfgr_pkg
// Shared types, constants and register indexes of the stroke font renderer.
//------------------------------------------------------------------------------
package sfgr_pkg;

	localparam int FONT_BYTES_DEF  = 8192;
	localparam int MAX_STROKES_DEF = 63;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_PEN  = 2'd1;
	localparam logic [1:0] OP_DRAW = 2'd2;

	localparam logic [1:0] CMD_MOVE = 2'd0;
	localparam logic [1:0] CMD_DRAW = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;

	localparam logic [2:0] REG_FIRST  = 3'd0;
	localparam logic [2:0] REG_COUNT  = 3'd1;
	localparam logic [2:0] REG_TARGET = 3'd2;
	localparam logic [2:0] REG_NATIVE = 3'd3;
	localparam logic [2:0] REG_CAP    = 3'd4;
	localparam logic [2:0] REG_COLOR  = 3'd5;

	localparam logic [7:0] SPACE_CODE = 8'd32;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD_IN,
		DP_RD_OFF_LO,
		DP_RD_OFF_HI,
		DP_OFF_SET,
		DP_RD_X,
		DP_RD_Y,
		DP_GET_Y,
		DP_RD_WIDTH,
		DP_GET_W,
		DP_MUL_CAP,
		DP_MUL_X,
		DP_MUL_Y,
		DP_MUL_W,
		DP_DIV,
		DP_PEN_SET,
		DP_X_SAVE,
		DP_PT,
		DP_ADV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   mem_wr;
		logic   stroke_clr;
		logic   trunc;
	} sfgr_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic x_flag;
		logic y_flag;
		logic limit;
	} sfgr_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WR,
		ST_CAP_MUL,
		ST_CAP_DIV,
		ST_CAP_WAIT,
		ST_OFF_LO,
		ST_OFF_HI,
		ST_OFF_GET,
		ST_RD_X,
		ST_RD_Y,
		ST_GET_Y,
		ST_DEC,
		ST_X_MUL,
		ST_X_DIV,
		ST_X_WAIT,
		ST_Y_MUL,
		ST_Y_DIV,
		ST_Y_WAIT,
		ST_EMIT,
		ST_W_RD,
		ST_W_GET,
		ST_W_MUL,
		ST_W_DIV,
		ST_W_WAIT,
		ST_END
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
		if (v > 26'sd32767) begin
			return 16'sh7fff;
		end else if (v < -26'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

>>> sv/sfgr_ram.sv
//------------------------------------------------------------------------------
// sfgr_ram
// Generic single-port RAM with registered read data.
//------------------------------------------------------------------------------
module sfgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> sv/sfgr_div.sv
//------------------------------------------------------------------------------
// sfgr_div
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
//------------------------------------------------------------------------------
module sfgr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [18:0]  num,
	input  logic [7:0]          den,
	output logic                busy,
	output logic signed [18:0]  quo
);
	logic [18:0] rem_q;
	logic [18:0] acc_q;
	logic [7:0]  den_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [19:0] trial;
	logic [18:0] mag;

	assign busy  = (cnt_q != 5'd0);
	assign mag   = num[18] ? 19'(-num) : num;
	assign trial = {rem_q, acc_q[18]} - {12'd0, den_q};
	assign quo   = neg_q ? 19'(-acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd19;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			acc_q <= mag;
			den_q <= (den == 8'd0) ? 8'd1 : den;
			neg_q <= num[18];
		end else if (busy) begin
			if (!trial[19]) begin
				rem_q <= trial[18:0];
				acc_q <= {acc_q[17:0], 1'b1};
			end else begin
				rem_q <= {rem_q[17:0], acc_q[18]};
				acc_q <= {acc_q[17:0], 1'b0};
			end
		end
	end
endmodule

>>> sv/sfgr_datapath.sv
//------------------------------------------------------------------------------
// sfgr_datapath
// Registers, font memory, scaling multiplier and divider of the renderer.
//------------------------------------------------------------------------------
module sfgr_datapath #(
	parameter int FONT_BYTES  = sfgr_pkg::FONT_BYTES_DEF,
	parameter int MAX_STROKES = sfgr_pkg::MAX_STROKES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfgr_pkg::sfgr_cmd_t cmd,
	output sfgr_pkg::sfgr_sts_t sts,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [9:0]          cfg_data,
	input  logic [12:0]         in_addr,
	input  logic [7:0]          in_byte,
	input  logic [7:0]          in_code,
	input  logic [15:0]         in_x,
	input  logic [15:0]         in_y,
	output logic [1:0]          o_cmd,
	output logic [15:0]         o_x,
	output logic [15:0]         o_y,
	output logic [7:0]          o_color,
	output logic                o_trunc
);
	import sfgr_pkg::*;

	localparam int AW = $clog2(FONT_BYTES);
	localparam int SW = $clog2(MAX_STROKES + 1);

	logic [7:0]  first_q, count_q, native_q, color_q;
	logic [9:0]  target_q;
	logic signed [7:0] cap_q;

	logic [12:0] laddr_q;
	logic [7:0]  lbyte_q, idx_q, off_lo_q, bx_q, by_q, wp_q;
	logic signed [15:0] sx_q, sy_q;
	logic signed [15:0] pen_x_q, pen_y_q;
	logic [AW-1:0] ptr_q;
	logic [SW-1:0] strokes_q;
	logic signed [18:0] prod_q;
	logic signed [18:0] dx_q;

	logic [AW-1:0] addr;
	logic [7:0]    rdata;
	logic          div_start, div_busy;
	logic signed [18:0] quo;
	logic signed [18:0] tgt_ext;
	logic signed [15:0] adv_x;
	logic [8:0]    top;
	logic [7:0]    code_eff;
	logic [17:0]   base3;

	assign top      = {1'b0, first_q} + {1'b0, count_q};
	assign code_eff = (in_code < first_q || {1'b0, in_code} >= top) ? SPACE_CODE : in_code;
	assign base3    = 18'(count_q) * 18'd3;
	assign tgt_ext  = $signed({9'd0, target_q});
	assign adv_x    = sat16(26'(pen_x_q) + 26'(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 8'd32;
			count_q  <= 8'd95;
			target_q <= 10'd10;
			native_q <= 8'd10;
			cap_q    <= 8'sd0;
			color_q  <= 8'd15;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FIRST:  first_q  <= cfg_data[7:0];
				REG_COUNT:  count_q  <= cfg_data[7:0];
				REG_TARGET: target_q <= cfg_data;
				REG_NATIVE: native_q <= cfg_data[7:0];
				REG_CAP:    cap_q    <= cfg_data[7:0];
				REG_COLOR:  color_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.op)
			DP_RD_OFF_LO: addr = AW'({idx_q, 1'b0});
			DP_RD_OFF_HI: addr = AW'({idx_q, 1'b1});
			DP_RD_WIDTH:  addr = AW'(10'({count_q, 1'b0}) + 10'(idx_q));
			DP_RD_X:      addr = ptr_q;
			DP_RD_Y:      addr = ptr_q + AW'(1);
			default:      addr = AW'(laddr_q);
		endcase
	end

	sfgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_ram (
		.clk(clk), .we(cmd.mem_wr), .addr(addr), .wdata(lbyte_q), .rdata(rdata)
	);

	assign div_start = (cmd.op == DP_DIV);
	sfgr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_q),
		.den(native_q), .busy(div_busy), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q   <= '0;
			pen_y_q   <= '0;
			strokes_q <= '0;
		end else begin
			if (cmd.stroke_clr) begin
				strokes_q <= '0;
			end else if (cmd.op == DP_RD_X) begin
				strokes_q <= strokes_q + SW'(1);
			end
			unique case (cmd.op)
				DP_PEN_SET: begin
					pen_x_q <= sx_q;
					pen_y_q <= sat16(26'(sy_q) + 26'(quo));
				end
				DP_ADV: pen_x_q <= adv_x;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD_IN: begin
				laddr_q <= in_addr;
				lbyte_q <= in_byte;
				sx_q    <= in_x;
				sy_q    <= in_y;
				idx_q   <= code_eff - first_q;
			end
			DP_RD_OFF_HI: off_lo_q <= rdata;
			DP_OFF_SET:   ptr_q <= AW'(base3 + 18'($signed({rdata, off_lo_q})));
			DP_RD_Y:      bx_q <= rdata;
			DP_GET_Y: begin
				by_q  <= rdata;
				ptr_q <= ptr_q + AW'(2);
			end
			DP_GET_W:     wp_q <= rdata;
			DP_MUL_CAP:   prod_q <= tgt_ext * 19'(cap_q);
			DP_MUL_X:     prod_q <= tgt_ext * 19'($signed(bx_q[6:0]));
			DP_MUL_Y:     prod_q <= tgt_ext * 19'($signed(by_q[6:0]));
			DP_MUL_W:     prod_q <= tgt_ext * $signed({11'd0, wp_q}) + 19'sd1;
			DP_X_SAVE:    dx_q <= quo;
			DP_PT: begin
				o_cmd   <= by_q[7] ? CMD_DRAW : CMD_MOVE;
				o_x     <= sat16(26'(pen_x_q) + 26'(dx_q));
				o_y     <= sat16(26'(pen_y_q) - 26'(quo));
				o_color <= by_q[7] ? color_q : 8'd0;
				o_trunc <= 1'b0;
			end
			DP_ADV: begin
				o_cmd   <= CMD_END;
				o_x     <= adv_x;
				o_y     <= pen_y_q;
				o_color <= 8'd0;
				o_trunc <= cmd.trunc;
			end
			default: ;
		endcase
	end

	assign sts.div_busy = div_busy;
	assign sts.x_flag   = bx_q[7];
	assign sts.y_flag   = by_q[7];
	assign sts.limit    = (strokes_q >= SW'(MAX_STROKES));
endmodule

>>> sv/sfgr_ctrl.sv
//------------------------------------------------------------------------------
// sfgr_ctrl
// Sequencer that walks one item through the datapath.
//------------------------------------------------------------------------------
module sfgr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_opcode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_last,
	output sfgr_pkg::sfgr_cmd_t cmd,
	input  sfgr_pkg::sfgr_sts_t sts
);
	import sfgr_pkg::*;

	state_t state_q, state_d;
	logic   ended_q, ended_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ended_q <= ended_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ended_d   = ended_q;
		cmd       = '{op: DP_NONE, mem_wr: 1'b0, stroke_clr: 1'b0, trunc: !ended_q};
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = DP_LOAD_IN;
					unique case (in_opcode)
						OP_LOAD: state_d = ST_WR;
						OP_PEN:  state_d = ST_CAP_MUL;
						OP_DRAW: state_d = ST_OFF_LO;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR: begin
				cmd.mem_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CAP_MUL: begin
				cmd.op = DP_MUL_CAP;
				state_d = ST_CAP_DIV;
			end
			ST_CAP_DIV: begin
				cmd.op = DP_DIV;
				state_d = ST_CAP_WAIT;
			end
			ST_CAP_WAIT: begin
				if (!sts.div_busy) begin
					cmd.op = DP_PEN_SET;
					state_d = ST_IDLE;
				end
			end
			ST_OFF_LO: begin
				cmd.op = DP_RD_OFF_LO;
				cmd.stroke_clr = 1'b1;
				ended_d = 1'b0;
				state_d = ST_OFF_HI;
			end
			ST_OFF_HI: begin
				cmd.op = DP_RD_OFF_HI;
				state_d = ST_OFF_GET;
			end
			ST_OFF_GET: begin
				cmd.op = DP_OFF_SET;
				state_d = ST_RD_X;
			end
			ST_RD_X: begin
				if (sts.limit) begin
					state_d = ST_W_RD;
				end else begin
					cmd.op = DP_RD_X;
					state_d = ST_RD_Y;
				end
			end
			ST_RD_Y: begin
				cmd.op = DP_RD_Y;
				state_d = ST_GET_Y;
			end
			ST_GET_Y: begin
				cmd.op = DP_GET_Y;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (sts.x_flag) begin
					state_d = ST_X_MUL;
				end else if (!sts.y_flag) begin
					ended_d = 1'b1;
					state_d = ST_W_RD;
				end else begin
					state_d = ST_RD_X;
				end
			end
			ST_X_MUL: begin
				cmd.op = DP_MUL_X;
				state_d = ST_X_DIV;
			end
			ST_X_DIV: begin
				cmd.op = DP_DIV;
				state_d = ST_X_WAIT;
			end
			ST_X_WAIT: begin
				if (!sts.div_busy) begin
					cmd.op = DP_X_SAVE;
					state_d = ST_Y_MUL;
				end
			end
			ST_Y_MUL: begin
				cmd.op = DP_MUL_Y;
				state_d = ST_Y_DIV;
			end
			ST_Y_DIV: begin
				cmd.op = DP_DIV;
				state_d = ST_Y_WAIT;
			end
			ST_Y_WAIT: begin
				if (!sts.div_busy) begin
					cmd.op = DP_PT;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_RD_X;
				end
			end
			ST_W_RD: begin
				cmd.op = DP_RD_WIDTH;
				state_d = ST_W_GET;
			end
			ST_W_GET: begin
				cmd.op = DP_GET_W;
				state_d = ST_W_MUL;
			end
			ST_W_MUL: begin
				cmd.op = DP_MUL_W;
				state_d = ST_W_DIV;
			end
			ST_W_DIV: begin
				cmd.op = DP_DIV;
				state_d = ST_W_WAIT;
			end
			ST_W_WAIT: begin
				if (!sts.div_busy) begin
					cmd.op = DP_ADV;
					state_d = ST_END;
				end
			end
			ST_END: begin
				out_valid = 1'b1;
				out_last = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> sv/stroke_font_glyph_renderer_top.sv
//------------------------------------------------------------------------------
// stroke_font_glyph_renderer_top
// Stroke font renderer: font bytes in, move, draw and end commands out.
//------------------------------------------------------------------------------
// One item at a time: s_tready is high only while the sequencer is idle. A draw
// fetches the glyph offset, reads each stroke word, scales each move or draw
// word, and then produces the width, pen advance and end result; any result can
// wait for m_tready. The serial divider is run twice per point.
// FONT_BYTES must be a power of two.
module stroke_font_glyph_renderer_top #(
	parameter int FONT_BYTES  = sfgr_pkg::FONT_BYTES_DEF,
	parameter int MAX_STROKES = sfgr_pkg::MAX_STROKES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], font_addr[14:2], font_byte[22:15], char_code[30:23],
	// start_x[46:31], start_y[62:47], zero fill [63]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// command[1:0], point_x[17:2], point_y[33:18], color[41:34], truncated[42],
	// zero fill [47:43]
	output logic [47:0] m_tdata,
	output logic        m_tlast
);
	import sfgr_pkg::*;

	sfgr_cmd_t   cmd;
	sfgr_sts_t   sts;
	logic [1:0]  o_cmd;
	logic [15:0] o_x, o_y;
	logic [7:0]  o_color;
	logic        o_trunc;

	assign cfg_ready = 1'b1;

	sfgr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_opcode(s_tdata[1:0]),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
		.out_last(m_tlast), .cmd(cmd), .sts(sts)
	);

	sfgr_datapath #(.FONT_BYTES(FONT_BYTES), .MAX_STROKES(MAX_STROKES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_addr(s_tdata[14:2]), .in_byte(s_tdata[22:15]),
		.in_code(s_tdata[30:23]), .in_x(s_tdata[46:31]), .in_y(s_tdata[62:47]),
		.o_cmd(o_cmd), .o_x(o_x), .o_y(o_y), .o_color(o_color), .o_trunc(o_trunc)
	);

	assign m_tdata = {5'd0, o_trunc, o_color, o_y, o_x, o_cmd};
endmodule
